// ===== rtl/core/wrapped_texture_quad_tiler_defines.svh =====
// Assertion macros shared by the checking code of the quad tiler.
`ifndef WRAPPED_TEXTURE_QUAD_TILER_DEFINES_SVH
`define WRAPPED_TEXTURE_QUAD_TILER_DEFINES_SVH

// Implication that must hold in the same cycle, sampled on clk_i.
`define WTQT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence must hold in the next cycle.
`define WTQT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wtqt_pkg.sv =====
`default_nettype none

package wtqt_pkg;

  // Fixed-point constants of the texture walk (texture units are Q8.16).
  localparam int unsigned OneRepeat = 65536;
  localparam int unsigned EpsFix    = 655;
  localparam int unsigned CntW      = 8;

  localparam logic [12:0] TexSizeReset = 13'd256;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PRESENT = 2'd0,
    REG_TEX_W   = 2'd1,
    REG_TEX_H   = 2'd2
  } reg_idx_e;

  // How the back end handles a queued command.
  typedef enum logic {
    MODE_PLAIN = 1'b0,
    MODE_TILED = 1'b1
  } mode_e;

  typedef struct packed {
    logic signed [23:0] quad_x;
    logic signed [23:0] quad_y;
    logic        [22:0] quad_w;
    logic        [22:0] quad_h;
    logic signed [23:0] tex_u;
    logic signed [23:0] tex_v;
    logic        [22:0] tex_span_u;
    logic        [22:0] tex_span_v;
  } in_t;

  typedef struct packed {
    logic signed [23:0] scr_x0;
    logic signed [23:0] scr_y0;
    logic signed [23:0] scr_x1;
    logic signed [23:0] scr_y1;
    logic        [20:0] pix_x0;
    logic        [20:0] pix_y0;
    logic        [20:0] pix_x1;
    logic        [20:0] pix_y1;
    logic               last_tile;
    logic               truncated;
  } out_t;

  // One classified quad, as passed from the front end to the back end.
  typedef struct packed {
    mode_e              mode;
    logic signed [23:0] qx;
    logic signed [23:0] qy;
    logic        [22:0] qw;
    logic        [22:0] qh;
    logic        [22:0] ox;
    logic        [22:0] oy;
    logic        [22:0] su;
    logic        [22:0] sv;
    logic [CntW-1:0]    ny;
    logic [CntW-1:0]    n;
    logic               trunc;
  } cmd_t;

  // Size of the cell that starts at p on an axis that ends at e (p < e).
  function automatic logic [16:0] cell_size(input logic [23:0] p, input logic [23:0] e);
    logic [25:0] t;
    logic [25:0] c;
    logic [25:0] s;
    t = {2'b00, p} + 26'(EpsFix + OneRepeat - 1);
    c = {t[25:16], 16'h0000};
    s = c - {2'b00, p};
    if (s > 26'(OneRepeat)) begin
      s = 26'(OneRepeat);
    end
    if (({2'b00, p} + s) > {2'b00, e}) begin
      s = {2'b00, e} - {2'b00, p};
    end
    return s[16:0];
  endfunction

  // Number of cells on one axis, from its origin and span.
  function automatic logic [CntW-1:0] axis_count(input logic [22:0] o,
                                                 input logic [22:0] span);
    logic [23:0] e;
    logic [16:0] s0;
    logic [22:0] rest;
    logic [23:0] t;
    e    = {1'b0, o} + {1'b0, span};
    s0   = cell_size({1'b0, o}, e);
    rest = span - {6'b0, s0};
    t    = {1'b0, rest} + 24'(OneRepeat - 1);
    if (span == 23'd0) begin
      return '0;
    end else if ({1'b0, span} <= {7'b0, s0}) begin
      return CntW'(1);
    end else begin
      return CntW'(t[23:16]) + CntW'(1);
    end
  endfunction

  // Clamp a screen coordinate to the signed 24-bit range.
  function automatic logic signed [23:0] sat_scr(input logic signed [24:0] v);
    if (v > 25'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -25'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

  // Texture pixel coordinate of a Q1.16 position, saturated to 21 bits.
  function automatic logic [20:0] pix_scale(input logic [16:0] f, input logic [12:0] size);
    logic [29:0] prod;
    prod = {13'b0, f} * {17'b0, size};
    if (prod[29] == 1'b1) begin
      return 21'h1FFFFF;
    end else begin
      return prod[28:8];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wtqt_in_if.sv =====
`default_nettype none

interface wtqt_in_if;
  import wtqt_pkg::*;

  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wtqt_out_if.sv =====
`default_nettype none

interface wtqt_out_if;
  import wtqt_pkg::*;

  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wtqt_front.sv =====
`default_nettype none

module wtqt_front #(
  parameter int unsigned MAX_TILES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            present_i,
  wtqt_in_if.sink         in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output wtqt_pkg::cmd_t  push_cmd_o
);
  import wtqt_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_COUNT = 3'b010,
    F_PUSH  = 3'b100
  } front_state_e;

  front_state_e    state_q, state_d;
  in_t             in_q, in_d;
  logic            plain_q, plain_d;
  logic [CntW-1:0] nx_q, nx_d;
  logic [CntW-1:0] ny_q, ny_d;

  logic [22:0]     ox, oy;
  logic [15:0]     n_raw;
  logic            trunc;

  assign in_i.ready = (state_q == F_IDLE);

  // A negative origin keeps only its fraction.
  assign ox = in_q.tex_u[23] ? {7'b0, in_q.tex_u[15:0]} : in_q.tex_u[22:0];
  assign oy = in_q.tex_v[23] ? {7'b0, in_q.tex_v[15:0]} : in_q.tex_v[22:0];

  // Cell total and the tile limit.
  assign n_raw = {8'b0, nx_q} * {8'b0, ny_q};
  assign trunc = n_raw > 16'(MAX_TILES);

  assign push_valid_o = (state_q == F_PUSH) && (plain_q || (n_raw != 16'd0));

  always_comb begin
    push_cmd_o.mode  = plain_q ? MODE_PLAIN : MODE_TILED;
    push_cmd_o.qx    = in_q.quad_x;
    push_cmd_o.qy    = in_q.quad_y;
    push_cmd_o.qw    = in_q.quad_w;
    push_cmd_o.qh    = in_q.quad_h;
    push_cmd_o.ox    = ox;
    push_cmd_o.oy    = oy;
    push_cmd_o.su    = in_q.tex_span_u;
    push_cmd_o.sv    = in_q.tex_span_v;
    push_cmd_o.ny    = plain_q ? CntW'(1) : ny_q;
    push_cmd_o.n     = plain_q ? CntW'(1) : (trunc ? CntW'(MAX_TILES) : n_raw[CntW-1:0]);
    push_cmd_o.trunc = plain_q ? 1'b0 : trunc;
  end

  // Accept, count cells if textured, then queue it unless it has no cells.
  always_comb begin
    state_d = state_q;
    in_d    = in_q;
    plain_d = plain_q;
    nx_d    = nx_q;
    ny_d    = ny_q;
    case (state_q)
      F_IDLE: begin
        if (in_i.valid) begin
          in_d    = in_i.data;
          plain_d = !present_i;
          state_d = present_i ? F_COUNT : F_PUSH;
        end
      end
      F_COUNT: begin
        nx_d    = axis_count(ox, in_q.tex_span_u);
        ny_d    = axis_count(oy, in_q.tex_span_v);
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!push_valid_o || push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    plain_q <= plain_d;
    nx_q    <= nx_d;
    ny_q    <= ny_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/wtqt_fifo.sv =====
`default_nettype none

module wtqt_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  wtqt_pkg::cmd_t  push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output wtqt_pkg::cmd_t  pop_cmd_o
);
  import wtqt_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wtqt_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit a cycle. The caller guarantees that
// the quotient fits in 23 bits (num < den * 2^23).
module wtqt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [45:0] num_i,
  input  logic [22:0] den_i,
  output logic        done_o,
  output logic [22:0] quo_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [22:0] rem_q, rem_d;
  logic [22:0] low_q, low_d;
  logic [22:0] den_q, den_d;
  logic [23:0] trial;
  logic [23:0] diff;
  logic        ge;

  assign trial  = {rem_q, low_q[22]};
  assign diff   = trial - {1'b0, den_q};
  assign ge     = trial >= {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = low_q;

  // Load on start, then shift in one dividend bit and try a subtraction.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd23;
      rem_d  = num_i[45:23];
      low_d  = num_i[22:0];
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[22:0] : trial[22:0];
      low_d = {low_q[21:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/wtqt_back.sv =====
`default_nettype none

module wtqt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [12:0]     tex_w_i,
  input  logic [12:0]     tex_h_i,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  wtqt_pkg::cmd_t  pop_cmd_i,
  wtqt_out_if.source      out_o
);
  import wtqt_pkg::*;

  typedef enum logic [10:0] {
    B_IDLE   = 11'b00000000001,
    B_COL    = 11'b00000000010,
    B_XMUL   = 11'b00000000100,
    B_XSTART = 11'b00000001000,
    B_XWAIT  = 11'b00000010000,
    B_ROW    = 11'b00000100000,
    B_YMUL   = 11'b00001000000,
    B_YSTART = 11'b00010000000,
    B_YWAIT  = 11'b00100000000,
    B_PIXM   = 11'b01000000000,
    B_EMIT   = 11'b10000000000
  } back_state_e;

  back_state_e        state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [23:0]        px_q, px_d, py_q, py_d;
  logic [16:0]        sx_q, sx_d, sy_q, sy_d;
  logic signed [24:0] xe0_q, xe0_d, xe1_q, xe1_d;
  logic signed [24:0] ye0_q, ye0_d, ye1_q, ye1_d;
  logic [CntW-1:0]    row_q, row_d, emit_q, emit_d;
  logic [45:0]        prod_q, prod_d;
  logic [20:0]        pix_x0_q, pix_x0_d, pix_y0_q, pix_y0_d;
  logic [20:0]        pix_x1_q, pix_x1_d, pix_y1_q, pix_y1_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic [23:0]        ex, ey, dx1, dy1;
  logic [16:0]        fx, fy, fx1, fy1;
  logic               div_start, div_done;
  logic [22:0]        div_den, div_quo;
  logic               load_out, is_last;

  assign ex  = {1'b0, cmd_q.ox} + {1'b0, cmd_q.su};
  assign ey  = {1'b0, cmd_q.oy} + {1'b0, cmd_q.sv};
  assign dx1 = px_q - {1'b0, cmd_q.ox} + {7'b0, sx_q};
  assign dy1 = py_q - {1'b0, cmd_q.oy} + {7'b0, sy_q};
  assign fx  = {1'b0, px_q[15:0]};
  assign fy  = {1'b0, py_q[15:0]};
  assign fx1 = fx + sx_q;
  assign fy1 = fy + sy_q;

  // One divider serves the column edge and the row edge in turn.
  assign div_start = (state_q == B_XSTART) || (state_q == B_YSTART);
  assign div_den   = (state_q == B_YSTART) ? cmd_q.sv : cmd_q.su;

  wtqt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (prod_q),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign pop_ready_o = (state_q == B_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign load_out    = (state_q == B_EMIT) && (!out_valid_q || out_o.ready);
  assign is_last     = ((emit_q + CntW'(1)) == cmd_q.n);

  // Walk sequencer: columns outside, rows inside.
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    px_d     = px_q;
    py_d     = py_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    xe0_d    = xe0_q;
    xe1_d    = xe1_q;
    ye0_d    = ye0_q;
    ye1_d    = ye1_q;
    row_d    = row_q;
    emit_d   = emit_q;
    prod_d   = prod_q;
    pix_x0_d = pix_x0_q;
    pix_y0_d = pix_y0_q;
    pix_x1_d = pix_x1_q;
    pix_y1_d = pix_y1_q;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          cmd_d  = pop_cmd_i;
          px_d   = {1'b0, pop_cmd_i.ox};
          py_d   = {1'b0, pop_cmd_i.oy};
          xe0_d  = {pop_cmd_i.qx[23], pop_cmd_i.qx};
          ye0_d  = {pop_cmd_i.qy[23], pop_cmd_i.qy};
          row_d  = '0;
          emit_d = '0;
          if (pop_cmd_i.mode == MODE_PLAIN) begin
            xe1_d    = {pop_cmd_i.qx[23], pop_cmd_i.qx} + {2'b00, pop_cmd_i.qw};
            ye1_d    = {pop_cmd_i.qy[23], pop_cmd_i.qy} + {2'b00, pop_cmd_i.qh};
            pix_x0_d = '0;
            pix_y0_d = '0;
            pix_x1_d = '0;
            pix_y1_d = '0;
            state_d  = B_EMIT;
          end else begin
            state_d = B_COL;
          end
        end
      end
      B_COL: begin
        sx_d    = cell_size(px_q, ex);
        state_d = B_XMUL;
      end
      B_XMUL: begin
        prod_d  = {23'b0, dx1[22:0]} * {23'b0, cmd_q.qw};
        state_d = B_XSTART;
      end
      B_XSTART: state_d = B_XWAIT;
      B_XWAIT: begin
        if (div_done) begin
          xe1_d   = {cmd_q.qx[23], cmd_q.qx} + {2'b00, div_quo};
          state_d = B_ROW;
        end
      end
      B_ROW: begin
        sy_d    = cell_size(py_q, ey);
        state_d = B_YMUL;
      end
      B_YMUL: begin
        prod_d  = {23'b0, dy1[22:0]} * {23'b0, cmd_q.qh};
        state_d = B_YSTART;
      end
      B_YSTART: state_d = B_YWAIT;
      B_YWAIT: begin
        if (div_done) begin
          ye1_d   = {cmd_q.qy[23], cmd_q.qy} + {2'b00, div_quo};
          state_d = B_PIXM;
        end
      end
      B_PIXM: begin
        pix_x0_d = pix_scale(fx, tex_w_i);
        pix_x1_d = pix_scale(fx1, tex_w_i);
        pix_y0_d = pix_scale(fy, tex_h_i);
        pix_y1_d = pix_scale(fy1, tex_h_i);
        state_d  = B_EMIT;
      end
      B_EMIT: begin
        if (load_out) begin
          if (is_last) begin
            state_d = B_IDLE;
          end else begin
            emit_d = emit_q + CntW'(1);
            if ((row_q + CntW'(1)) == cmd_q.ny) begin
              px_d    = px_q + {7'b0, sx_q};
              xe0_d   = xe1_q;
              py_d    = {1'b0, cmd_q.oy};
              ye0_d   = {cmd_q.qy[23], cmd_q.qy};
              row_d   = '0;
              state_d = B_COL;
            end else begin
              py_d    = py_q + {7'b0, sy_q};
              ye0_d   = ye1_q;
              row_d   = row_q + CntW'(1);
              state_d = B_ROW;
            end
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Output register: holds a finished word until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d     = 1'b1;
      out_d.scr_x0    = sat_scr(xe0_q);
      out_d.scr_y0    = sat_scr(ye0_q);
      out_d.scr_x1    = sat_scr(xe1_q);
      out_d.scr_y1    = sat_scr(ye1_q);
      out_d.pix_x0    = pix_x0_q;
      out_d.pix_y0    = pix_y0_q;
      out_d.pix_x1    = pix_x1_q;
      out_d.pix_y1    = pix_y1_q;
      out_d.last_tile = is_last;
      out_d.truncated = cmd_q.trunc;
    end else if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      row_q       <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    px_q     <= px_d;
    py_q     <= py_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    xe0_q    <= xe0_d;
    xe1_q    <= xe1_d;
    ye0_q    <= ye0_d;
    ye1_q    <= ye1_d;
    prod_q   <= prod_d;
    pix_x0_q <= pix_x0_d;
    pix_y0_q <= pix_y0_d;
    pix_x1_q <= pix_x1_d;
    pix_y1_q <= pix_y1_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/wrapped_texture_quad_tiler.sv =====
// Wrapped texture quad tiler.
// in_i takes one quad word (screen rectangle plus texture rectangle in
// repeats); out_o gives one sub-quad word per texture cell, columns first,
// with last_tile on the final word and truncated on every word of a quad
// whose cells exceeded MAX_TILES. Both are valid/ready channels.
// The cfg port writes texture_present (index 0), texture_width (1) and
// texture_height (2); write it only while the block is idle.
// The front end takes a quad, counts its cells and queues it (two
// entries). The back end walks each column and each cell in turn,
// with the shared 23-step divider computing each screen edge; it takes
// no new quad from the queue until the last word of the current one is
// loaded. An untextured quad skips the divider and gives its one word.
// Reset clears the queue and both sequencers and restores texture_present=1
// and a 256 x 256 texture; no clearing pass is needed.
// When the receiver stalls, the output register holds its word, the back
// end waits, and the queue and then the front end fill before in_i.ready
// falls.
`default_nettype none

module wrapped_texture_quad_tiler #(
  parameter int unsigned MAX_TILES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  wtqt_in_if.sink     in_i,
  wtqt_out_if.source  out_o
);
  import wtqt_pkg::*;

  logic        present_q, present_d;
  logic [12:0] tex_w_q, tex_w_d;
  logic [12:0] tex_h_q, tex_h_d;

  logic        push_valid, push_ready, pop_valid, pop_ready;
  cmd_t        push_cmd, pop_cmd;

  // Configuration registers.
  always_comb begin
    present_d = present_q;
    tex_w_d   = tex_w_q;
    tex_h_d   = tex_h_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PRESENT: present_d = cfg_data_i[0];
        REG_TEX_W:   tex_w_d   = cfg_data_i;
        REG_TEX_H:   tex_h_d   = cfg_data_i;
        default:     present_d = present_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b1;
      tex_w_q   <= TexSizeReset;
      tex_h_q   <= TexSizeReset;
    end else begin
      present_q <= present_d;
      tex_w_q   <= tex_w_d;
      tex_h_q   <= tex_h_d;
    end
  end

  wtqt_front #(.MAX_TILES(MAX_TILES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .present_i   (present_q),
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd)
  );

  wtqt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_cmd_o   (pop_cmd)
  );

  wtqt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tex_w_i    (tex_w_q),
    .tex_h_i    (tex_h_q),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_cmd_i  (pop_cmd),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/wtqt_checker.sv =====
`default_nettype none
`include "wrapped_texture_quad_tiler_defines.svh"

module wtqt_checker #(
  parameter int unsigned MAX_TILES = 64
) (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_last_i,
  input logic out_trunc_i
);

  localparam int unsigned CW = $clog2(MAX_TILES + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          first_q, first_d;
  logic          trunc_q, trunc_d;
  logic          take;

  assign take = out_valid_i && out_ready_i;

  // Track the words of the current quad at the output.
  always_comb begin
    cnt_d   = cnt_q;
    first_d = first_q;
    trunc_d = trunc_q;
    if (take) begin
      if (first_q) begin
        trunc_d = out_trunc_i;
      end
      if (out_last_i) begin
        cnt_d   = '0;
        first_d = 1'b1;
      end else begin
        cnt_d   = cnt_q + CW'(1);
        first_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      first_q <= 1'b1;
      trunc_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      first_q <= first_d;
      trunc_q <= trunc_d;
    end
  end

  `WTQT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "output word dropped while stalled")
  `WTQT_ASSERT_NOW(a_trunc_same, out_valid_i && !first_q, out_trunc_i == trunc_q, "truncated flag changed within a quad")
  `WTQT_ASSERT_NOW(a_tile_limit, out_valid_i, cnt_q < CW'(MAX_TILES), "more words than the tile limit")
  `WTQT_ASSERT_NOW(a_trunc_full, out_valid_i && out_last_i && out_trunc_i, cnt_q == CW'(MAX_TILES - 1), "truncated quad ended short of the tile limit")

endmodule

bind wrapped_texture_quad_tiler wtqt_checker #(.MAX_TILES(MAX_TILES)) u_wtqt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_last_i (out_o.data.last_tile),
  .out_trunc_i(out_o.data.truncated)
);

`default_nettype wire

// ===== sim/tb_wrapped_texture_quad_tiler.sv =====
`timescale 1ns / 1ps

module tb_wrapped_texture_quad_tiler;
  import wtqt_pkg::*;

  localparam int unsigned MaxTiles   = 64;
  localparam int unsigned SettleCyc  = 300;
  localparam longint      PixMax     = 64'h1F_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [12:0] cfg_data_i;

  wtqt_in_if  quad_if ();
  wtqt_out_if tile_if ();

  wrapped_texture_quad_tiler #(
    .MAX_TILES(MaxTiles)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (quad_if),
    .out_o     (tile_if)
  );

  // Local copy of the registers and the queue of sub-quads still awaited.
  logic        tex_on;
  logic [12:0] tex_w;
  logic [12:0] tex_h;
  out_t        tiles_due[$];
  int          n_fail;
  int          src_idle_pct;
  int          snk_idle_pct;
  int          hold_off_cyc;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #40ms;
    $display("** wrapped_texture_quad_tiler: FAILED **");
    $finish;
  end

  function automatic logic [23:0] clamp_scr(input longint v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic logic [20:0] tex_pix(input longint f, input logic [12:0] size);
    longint r;
    r = (f * longint'(size)) >>> 8;
    if (r > PixMax) r = PixMax;
    return r[20:0];
  endfunction

  // Size of the cell starting at p on an axis that ends at e.
  function automatic longint cell_len(input longint p, input longint e);
    longint c;
    longint s;
    c = ((p + EpsFix + 65535) >>> 16) <<< 16;
    s = c - p;
    if (s > OneRepeat) s = OneRepeat;
    if (p + s > e) s = e - p;
    return s;
  endfunction

  function automatic longint scr_edge(input longint base, input longint d,
                                      input longint qsize, input longint span);
    if (span == 0) return base;
    return base + (d * qsize) / span;
  endfunction

  // Work out the sub-quads of one quad and queue them.
  function automatic void tile_quad(input in_t q);
    out_t   cells[$];
    out_t   t;
    longint qx, qy, qw, qh, u, v, su, sv, eu, ev, ox, oy, sx, sy;
    bit     cut;
    qx = q.quad_x;
    qy = q.quad_y;
    qw = q.quad_w;
    qh = q.quad_h;
    u  = q.tex_u;
    v  = q.tex_v;
    su = q.tex_span_u;
    sv = q.tex_span_v;
    cut = 1'b0;
    if (!tex_on) begin
      t = '0;
      t.scr_x0 = clamp_scr(qx);
      t.scr_y0 = clamp_scr(qy);
      t.scr_x1 = clamp_scr(qx + qw);
      t.scr_y1 = clamp_scr(qy + qh);
      t.last_tile = 1'b1;
      tiles_due.push_back(t);
      return;
    end
    if (u < 0) u = u & 64'hFFFF;
    if (v < 0) v = v & 64'hFFFF;
    eu = u + su;
    ev = v + sv;
    ox = u;
    while (ox < eu && !cut) begin
      sx = cell_len(ox, eu);
      if (sx <= 0) break;
      oy = v;
      while (oy < ev) begin
        sy = cell_len(oy, ev);
        if (sy <= 0) break;
        if (cells.size() >= MaxTiles) begin
          cut = 1'b1;
          break;
        end
        t = '0;
        t.scr_x0 = clamp_scr(scr_edge(qx, ox - u, qw, su));
        t.scr_y0 = clamp_scr(scr_edge(qy, oy - v, qh, sv));
        t.scr_x1 = clamp_scr(scr_edge(qx, ox - u + sx, qw, su));
        t.scr_y1 = clamp_scr(scr_edge(qy, oy - v + sy, qh, sv));
        t.pix_x0 = tex_pix(ox & 64'hFFFF, tex_w);
        t.pix_y0 = tex_pix(oy & 64'hFFFF, tex_h);
        t.pix_x1 = tex_pix((ox & 64'hFFFF) + sx, tex_w);
        t.pix_y1 = tex_pix((oy & 64'hFFFF) + sy, tex_h);
        cells.push_back(t);
        oy += sy;
      end
      ox += sx;
    end
    foreach (cells[k]) begin
      cells[k].last_tile = (k == cells.size() - 1);
      cells[k].truncated = cut;
      tiles_due.push_back(cells[k]);
    end
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Receiver: takes sub-quad words, checks them and stalls at random.
  initial begin
    out_t e;
    out_t a;
    tile_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && tile_if.valid && tile_if.ready) begin
        a = tile_if.data;
        if (tiles_due.size() == 0) begin
          $error("unexpected sub-quad word");
          n_fail++;
        end else begin
          e = tiles_due.pop_front();
          check_field("scr_x0", longint'(e.scr_x0), longint'(a.scr_x0));
          check_field("scr_y0", longint'(e.scr_y0), longint'(a.scr_y0));
          check_field("scr_x1", longint'(e.scr_x1), longint'(a.scr_x1));
          check_field("scr_y1", longint'(e.scr_y1), longint'(a.scr_y1));
          check_field("pix_x0", longint'(e.pix_x0), longint'(a.pix_x0));
          check_field("pix_y0", longint'(e.pix_y0), longint'(a.pix_y0));
          check_field("pix_x1", longint'(e.pix_x1), longint'(a.pix_x1));
          check_field("pix_y1", longint'(e.pix_y1), longint'(a.pix_y1));
          check_field("last_tile", longint'(e.last_tile), longint'(a.last_tile));
          check_field("truncated", longint'(e.truncated), longint'(a.truncated));
        end
      end
      if (hold_off_cyc > 0) begin
        hold_off_cyc--;
        tile_if.ready <= 1'b0;
      end else begin
        tile_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Offer one quad word and predict its sub-quads once it is taken.
  task automatic send_quad(input in_t q);
    while ($urandom_range(99) < src_idle_pct) begin
      quad_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    quad_if.valid <= 1'b1;
    quad_if.data  <= q;
    do @(posedge clk_i); while (!quad_if.ready);
    tile_quad(q);
  endtask

  // Lower valid, wait for every awaited word and let the block settle.
  task automatic drain;
    quad_if.valid <= 1'b0;
    while (tiles_due.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [12:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_PRESENT: tex_on = val[0];
      REG_TEX_W:   tex_w  = val;
      default:     tex_h  = val;
    endcase
  endtask

  task automatic set_texture(input logic on, input logic [12:0] w, input logic [12:0] h);
    drain();
    write_reg(REG_PRESENT, {12'b0, on});
    write_reg(REG_TEX_W, w);
    write_reg(REG_TEX_H, h);
  endtask

  // Random quad; spans are mostly a few repeats, now and then full width.
  function automatic in_t rand_quad();
    in_t q;
    q.quad_x = 24'($urandom);
    q.quad_y = 24'($urandom);
    q.quad_w = 23'($urandom);
    q.quad_h = 23'($urandom);
    q.tex_u  = 24'($urandom);
    q.tex_v  = 24'($urandom);
    if ($urandom_range(3) == 0) q.tex_u[15:0] = 16'hFFFF - 16'($urandom_range(800));
    if ($urandom_range(3) == 0) q.tex_v[15:0] = 16'hFFFF - 16'($urandom_range(800));
    if ($urandom_range(39) == 0) begin
      q.tex_span_u = 23'($urandom);
      q.tex_span_v = 23'($urandom);
    end else begin
      q.tex_span_u = 23'($urandom_range(1, 3 * OneRepeat));
      q.tex_span_v = 23'($urandom_range(1, 3 * OneRepeat));
    end
    return q;
  endfunction

  function automatic in_t mk_quad(input longint x, input longint y, input longint w,
                                  input longint h, input longint u, input longint v,
                                  input longint su, input longint sv);
    in_t q;
    q.quad_x = x[23:0];
    q.quad_y = y[23:0];
    q.quad_w = w[22:0];
    q.quad_h = h[22:0];
    q.tex_u  = u[23:0];
    q.tex_v  = v[23:0];
    q.tex_span_u = su[22:0];
    q.tex_span_v = sv[22:0];
    return q;
  endfunction

  // Extremes, epsilon crossings, zero span, tile limit and odd texture sizes.
  task automatic test_directed;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_quad(mk_quad(0, 0, 256, 256, 0, 0, 65536, 65536));
    send_quad(mk_quad(8388607, 8388607, 8388607, 8388607, 0, 0, 131072, 65536));
    send_quad(mk_quad(-8388608, -8388608, 8388607, 0, -1, -65536, 1, 1));
    send_quad(mk_quad(100, 200, 300, 400, 65536 - 655, 65536 - 656, 70000, 70000));
    send_quad(mk_quad(100, 200, 0, 0, 65536 - 1, 0, 655, 65536 + 655));
    send_quad(mk_quad(5, 5, 5000, 5000, 8388607, 8388607, 8388607, 8388607));
    send_quad(mk_quad(0, 0, 100, 100, 0, 0, 9 * 65536, 9 * 65536));
    send_quad(mk_quad(0, 0, 100, 100, 0, 0, 0, 65536));
    send_quad(mk_quad(0, 0, 100, 100, 12345, 54321, 65536, 0));
    set_texture(1'b0, 13'd256, 13'd256);
    send_quad(mk_quad(8388607, -8388608, 8388607, 8388607, 0, 0, 0, 0));
    send_quad(mk_quad(-8388608, 8388607, 0, 0, 5, 5, 5, 5));
    send_quad(mk_quad(12, -34, 56, 78, -1, -1, 8388607, 8388607));
    set_texture(1'b1, 13'd0, 13'd8191);
    send_quad(mk_quad(0, 0, 1000, 1000, 65536 - 600, 32768, 200000, 100000));
    send_quad(mk_quad(-300, 300, 8388607, 1, 0, 0, 65536, 2 * 65536));
    set_texture(1'b1, 13'd4096, 13'd1);
    send_quad(mk_quad(0, 0, 1000, 1000, 65536 - 600, 65535, 200000, 100000));
    send_quad(mk_quad(7, 7, 7, 7, 1, 1, 1, 1));
    set_texture(1'b1, 13'd8191, 13'd4096);
    send_quad(mk_quad(0, 0, 1000, 1000, 65535, 65536 - 655, 131072, 131072));
    drain();
  endtask

  task automatic test_random(input int n_quads, input int src_pct, input int snk_pct);
    set_texture($urandom_range(7) != 0, 13'($urandom_range(8191)),
                13'($urandom_range(1, 4096)));
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int i = 0; i < n_quads; i++) begin
      if (i % 50 == 49) begin
        set_texture($urandom_range(7) != 0, 13'($urandom_range(1, 4096)),
                    13'($urandom_range(8191)));
      end
      send_quad(rand_quad());
    end
    drain();
  endtask

  // Long receiver stall while quads keep coming, then a sender pause.
  task automatic test_pressure;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_texture(1'b1, 13'd256, 13'd256);
    hold_off_cyc = 2000;
    for (int i = 0; i < 10; i++) send_quad(rand_quad());
    quad_if.valid <= 1'b0;
    while (tiles_due.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 10; i++) send_quad(rand_quad());
    drain();
  endtask

  // Stimulus sequence.
  initial begin
    n_fail       = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_off_cyc = 0;
    tex_on       = 1'b1;
    tex_w        = TexSizeReset;
    tex_h        = TexSizeReset;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_PRESENT;
    cfg_data_i   = '0;
    quad_if.valid = 1'b0;
    quad_if.data  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(145, 29, 54);
    test_random(145, 54, 29);
    test_random(145, 0, 0);
    test_pressure();

    if (n_fail == 0) begin
      $display("** wrapped_texture_quad_tiler: PASSED **");
    end else begin
      $display("** wrapped_texture_quad_tiler: FAILED **");
    end
    $finish;
  end

endmodule
